[rtl/fdrp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fdrp_pkg: shared definitions for the flash descriptor region parser
// Holds field widths, descriptor constants, result and status codes, the
// sequencer phase type and the structs passed between the parser modules.
// ----------------------------------------------------------------------------
package fdrp_pkg;

    // Field widths of the command and result words.
    localparam int CMD_W      = 1;
    localparam int DATA_W     = 32;
    localparam int ERR_W      = 3;
    localparam int KIND_W     = 2;
    localparam int ADDR_W     = 12;
    localparam int ID_W       = 4;
    localparam int BASE_W     = 28;
    localparam int SIZE_W     = 29;
    localparam int STATUS_W   = 2;
    localparam int COUNT_W    = 5;
    localparam int MASK_W     = 16;
    localparam int REGION_SHIFT = 12;
    localparam int HALF_W     = 16;

    // Region ids: the hardware limit and the default population.
    localparam int MAX_REGION_IDS     = 16;
    localparam int NUM_REGION_IDS_DEF = 16;

    // Configuration port.
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] REG_REGION_PRESENT_MASK = 1'b0;
    localparam logic [MASK_W-1:0]      MASK_RESET = 16'h0001;

    // Descriptor layout.
    localparam logic [DATA_W-1:0] SIGNATURE     = 32'h0FF0_A55A;
    localparam logic [ADDR_W-1:0] SIG_ADDR      = 12'h010;
    localparam logic [ADDR_W-1:0] MAP_ADDR      = 12'h018;
    localparam logic [3:0]        ACCESS_OFFSET = 4'hC;
    localparam logic [ADDR_W-1:0] REGION_TABLE  = 12'h040;
    localparam logic [REGION_SHIFT-1:0] MIN_REGION = 12'hFFF;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_START = 1'b0;
    localparam logic [CMD_W-1:0] CMD_DATA  = 1'b1;

    // Result kinds.
    localparam logic [KIND_W-1:0] KIND_REQUEST = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RECORD  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FINISH  = 2'd2;

    // Finish status codes.
    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_IO_ERROR   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_VALID  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NO_REGIONS = 2'd3;

    // Result queue depth: one word may leave while two new ones arrive.
    localparam int RQ_DEPTH = 3;
    localparam int RQ_CNT_W = 2;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SIG,
        PH_MAP,
        PH_ACCESS,
        PH_REGION
    } phase_t;

    typedef struct packed {
        phase_t              phase;
        logic [DATA_W-1:0]   access_word;
        logic [ID_W-1:0]     current_region;
        logic [BASE_W-1:0]   max_limit;
        logic [COUNT_W-1:0]  readable_total;
    } parse_state_t;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [DATA_W-1:0] read_data;
        logic [ERR_W-1:0]  read_error;
    } cmd_word_t;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [ADDR_W-1:0]   request_address;
        logic [ID_W-1:0]     region_id;
        logic [BASE_W-1:0]   region_base;
        logic [SIZE_W-1:0]   region_size;
        logic                readable;
        logic                writable;
        logic [STATUS_W-1:0] status;
        logic [SIZE_W-1:0]   total_size;
        logic [COUNT_W-1:0]  readable_count;
        logic                last;
    } result_t;

endpackage
`default_nettype wire

[rtl/fdrp_cmd_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fdrp_cmd_if: command channel of the region parser
// Carries start commands and returned descriptor words with a valid/ready
// handshake.
// ----------------------------------------------------------------------------
interface fdrp_cmd_if;
    import fdrp_pkg::*;

    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [DATA_W-1:0] read_data;
    logic [ERR_W-1:0]  read_error;

    modport source (
        output valid,
        output command,
        output read_data,
        output read_error,
        input  ready
    );

    modport sink (
        input  valid,
        input  command,
        input  read_data,
        input  read_error,
        output ready
    );
endinterface
`default_nettype wire

[rtl/fdrp_rsp_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fdrp_rsp_if: result channel of the region parser
// Carries read requests, region records and finish words with a valid/ready
// handshake.
// ----------------------------------------------------------------------------
interface fdrp_rsp_if;
    import fdrp_pkg::*;

    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [ADDR_W-1:0]   request_address;
    logic [ID_W-1:0]     region_id;
    logic [BASE_W-1:0]   region_base;
    logic [SIZE_W-1:0]   region_size;
    logic                readable;
    logic                writable;
    logic [STATUS_W-1:0] status;
    logic [SIZE_W-1:0]   total_size;
    logic [COUNT_W-1:0]  readable_count;
    logic                last;

    modport source (
        output valid,
        output kind,
        output request_address,
        output region_id,
        output region_base,
        output region_size,
        output readable,
        output writable,
        output status,
        output total_size,
        output readable_count,
        output last,
        input  ready
    );

    modport sink (
        input  valid,
        input  kind,
        input  request_address,
        input  region_id,
        input  region_base,
        input  region_size,
        input  readable,
        input  writable,
        input  status,
        input  total_size,
        input  readable_count,
        input  last,
        output ready
    );
endinterface
`default_nettype wire

[rtl/fdrp_step.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fdrp_step: next-state and result logic of the region parser
// Takes the registered command word and the current parse state, and gives
// the next state together with up to two result words.
// ----------------------------------------------------------------------------
module fdrp_step #(
    parameter int NUM_REGION_IDS = fdrp_pkg::NUM_REGION_IDS_DEF
) (
    input  fdrp_pkg::cmd_word_t          cmd_word,
    input  fdrp_pkg::parse_state_t       state_cur,
    input  logic [fdrp_pkg::MASK_W-1:0]  present_mask,
    output fdrp_pkg::parse_state_t       state_next,
    output logic [1:0]                   res_count,
    output fdrp_pkg::result_t            res0,
    output fdrp_pkg::result_t            res1
);
    import fdrp_pkg::*;

    // Lowest set bit of a candidate vector.
    function automatic logic [ID_W:0] pick_lowest(input logic [MASK_W-1:0] cand);
        logic [ID_W:0] found;
        found = '0;
        for (int i = MASK_W - 1; i >= 0; i--)
        begin
            if (cand[i])
            begin
                found = {1'b1, ID_W'(i)};
            end
        end
        return found;
    endfunction

    logic [MASK_W-1:0]  id_exists;
    logic [MASK_W-1:0]  eligible;
    logic [MASK_W-1:0]  above_cur;
    logic [ID_W:0]      first_pick;
    logic [ID_W:0]      next_pick;
    logic               data_err;
    logic [HALF_W-1:0]  base16;
    logic [HALF_W-1:0]  limit16;
    logic               region_off;
    logic [BASE_W-1:0]  region_base;
    logic [BASE_W-1:0]  region_limit;
    logic [HALF_W:0]    span;
    logic [COUNT_W-1:0] rd_bit_idx;
    logic [COUNT_W-1:0] wr_bit_idx;
    logic               rd_bit;
    logic               wr_bit;
    logic [BASE_W-1:0]  limit_upd;
    logic [COUNT_W-1:0] total_upd;
    result_t            rec;
    result_t            follow;

    // Ids that the configuration allows and that lie above the current one.
    always_comb
    begin
        for (int i = 0; i < MASK_W; i++)
        begin
            id_exists[i] = (i < NUM_REGION_IDS);
            above_cur[i] = (ID_W'(i) > state_cur.current_region);
        end
    end

    assign eligible   = present_mask & id_exists;
    assign first_pick = pick_lowest(eligible);
    assign next_pick  = pick_lowest(eligible & above_cur);
    assign data_err   = (cmd_word.read_error != '0);

    // Region word decode: base below limit is the same as low half not above
    // high half, since the limit carries the all-ones page offset.
    assign base16       = cmd_word.read_data[HALF_W-1:0];
    assign limit16      = cmd_word.read_data[DATA_W-1:HALF_W];
    assign region_off   = (base16 > limit16);
    assign region_base  = {base16, {REGION_SHIFT{1'b0}}};
    assign region_limit = {limit16, MIN_REGION};
    assign span         = {1'b0, limit16} - {1'b0, base16} + 1'b1;

    // Access word layout is split at id twelve.
    assign rd_bit_idx = (state_cur.current_region < ID_W'(12))
                      ? {1'b0, state_cur.current_region} + COUNT_W'(8)
                      : {1'b0, state_cur.current_region} - COUNT_W'(12);
    assign wr_bit_idx = (state_cur.current_region < ID_W'(12))
                      ? {1'b0, state_cur.current_region} + COUNT_W'(20)
                      : {1'b0, state_cur.current_region} - COUNT_W'(8);
    assign rd_bit = state_cur.access_word[rd_bit_idx];
    assign wr_bit = state_cur.access_word[wr_bit_idx];

    // Totals after this region.
    assign limit_upd = (!region_off && (state_cur.max_limit < region_limit))
                     ? region_limit : state_cur.max_limit;
    assign total_upd = (!region_off && rd_bit)
                     ? state_cur.readable_total + 1'b1 : state_cur.readable_total;

    // Region record word.
    always_comb
    begin
        rec           = '0;
        rec.kind      = KIND_RECORD;
        rec.region_id = state_cur.current_region;
        if (!region_off)
        begin
            rec.region_base = region_base;
            rec.region_size = {span, {REGION_SHIFT{1'b0}}};
            rec.readable    = rd_bit;
            rec.writable    = wr_bit;
        end
    end

    // Word that follows a region record: next request or the finish.
    always_comb
    begin
        follow      = '0;
        follow.last = 1'b1;
        if (next_pick[ID_W])
        begin
            follow.kind            = KIND_REQUEST;
            follow.request_address = REGION_TABLE
                                   + {{(ADDR_W-ID_W-2){1'b0}}, next_pick[ID_W-1:0], 2'b00};
        end
        else
        begin
            follow.kind           = KIND_FINISH;
            follow.status         = ST_OK;
            follow.total_size     = {1'b0, limit_upd} + 1'b1;
            follow.readable_count = total_upd;
        end
    end

    // Sequencer decision.
    always_comb
    begin
        state_next = state_cur;
        res_count  = 2'd0;
        res0       = '0;
        res1       = '0;
        res0.last  = 1'b1;
        if (cmd_word.command == CMD_START)
        begin
            state_next.access_word    = '0;
            state_next.current_region = '0;
            state_next.max_limit      = '0;
            state_next.readable_total = '0;
            res_count                 = 2'd1;
            if (!first_pick[ID_W])
            begin
                state_next.phase = PH_IDLE;
                res0.kind        = KIND_FINISH;
                res0.status      = ST_NO_REGIONS;
            end
            else
            begin
                state_next.phase     = PH_SIG;
                res0.kind            = KIND_REQUEST;
                res0.request_address = SIG_ADDR;
            end
        end
        else
        begin
            unique case (state_cur.phase)
                PH_SIG:
                begin
                    res_count = 2'd1;
                    if (data_err || (cmd_word.read_data != SIGNATURE))
                    begin
                        state_next.phase = PH_IDLE;
                        res0.kind        = KIND_FINISH;
                        res0.status      = data_err ? ST_IO_ERROR : ST_NOT_VALID;
                    end
                    else
                    begin
                        state_next.phase     = PH_MAP;
                        res0.kind            = KIND_REQUEST;
                        res0.request_address = MAP_ADDR;
                    end
                end
                PH_MAP:
                begin
                    res_count = 2'd1;
                    if (data_err)
                    begin
                        state_next.phase = PH_IDLE;
                        res0.kind        = KIND_FINISH;
                        res0.status      = ST_IO_ERROR;
                    end
                    else
                    begin
                        state_next.phase     = PH_ACCESS;
                        res0.kind            = KIND_REQUEST;
                        res0.request_address = {cmd_word.read_data[7:0], ACCESS_OFFSET};
                    end
                end
                PH_ACCESS:
                begin
                    res_count = 2'd1;
                    if (data_err)
                    begin
                        state_next.phase = PH_IDLE;
                        res0.kind        = KIND_FINISH;
                        res0.status      = ST_IO_ERROR;
                    end
                    else
                    begin
                        state_next.access_word = cmd_word.read_data;
                        if (!first_pick[ID_W])
                        begin
                            state_next.phase = PH_IDLE;
                            res0.kind        = KIND_FINISH;
                            res0.status      = ST_NO_REGIONS;
                        end
                        else
                        begin
                            state_next.phase          = PH_REGION;
                            state_next.current_region = first_pick[ID_W-1:0];
                            res0.kind                 = KIND_REQUEST;
                            res0.request_address      = REGION_TABLE
                                + {{(ADDR_W-ID_W-2){1'b0}}, first_pick[ID_W-1:0], 2'b00};
                        end
                    end
                end
                PH_REGION:
                begin
                    res_count                 = 2'd2;
                    res0                      = rec;
                    res1                      = follow;
                    state_next.max_limit      = limit_upd;
                    state_next.readable_total = total_upd;
                    if (next_pick[ID_W])
                    begin
                        state_next.current_region = next_pick[ID_W-1:0];
                    end
                    else
                    begin
                        state_next.phase = PH_IDLE;
                    end
                end
                default:
                begin
                    res_count = 2'd0;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

[rtl/fdrp_result_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fdrp_result_queue: three-entry shift queue for result words
// Takes up to two words a cycle and presents the oldest on the result
// channel. Reports room when two words fit after this cycle's pop.
// ----------------------------------------------------------------------------
module fdrp_result_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [1:0]           push_count,
    input  fdrp_pkg::result_t    push0,
    input  fdrp_pkg::result_t    push1,
    output logic                 room,
    fdrp_rsp_if.source           rsp
);
    import fdrp_pkg::*;

    result_t               q_reg [RQ_DEPTH];
    result_t               q_next [RQ_DEPTH];
    logic [RQ_CNT_W-1:0]   cnt_reg;
    logic [RQ_CNT_W-1:0]   cnt_next;
    logic [RQ_CNT_W-1:0]   kept;
    logic                  pop;

    assign pop  = (cnt_reg != '0) && rsp.ready;
    assign kept = cnt_reg - RQ_CNT_W'(pop);
    assign room = (kept < RQ_CNT_W'(2));

    // Shift out the popped word, then place new words behind the kept ones.
    always_comb
    begin
        for (int i = 0; i < RQ_DEPTH; i++)
        begin
            if (pop && (i + 1 < RQ_DEPTH))
            begin
                q_next[i] = q_reg[i + 1];
            end
            else
            begin
                q_next[i] = q_reg[i];
            end
            if ((push_count != 2'd0) && (RQ_CNT_W'(i) == kept))
            begin
                q_next[i] = push0;
            end
            if ((push_count == 2'd2) && (RQ_CNT_W'(i) == kept + 1'b1))
            begin
                q_next[i] = push1;
            end
        end
        cnt_next = kept + push_count;
    end

    // Occupancy count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // Word storage.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < RQ_DEPTH; i++)
        begin
            q_reg[i] <= q_next[i];
        end
    end

    // Head of the queue drives the channel.
    assign rsp.valid           = (cnt_reg != '0);
    assign rsp.kind            = q_reg[0].kind;
    assign rsp.request_address = q_reg[0].request_address;
    assign rsp.region_id       = q_reg[0].region_id;
    assign rsp.region_base     = q_reg[0].region_base;
    assign rsp.region_size     = q_reg[0].region_size;
    assign rsp.readable        = q_reg[0].readable;
    assign rsp.writable        = q_reg[0].writable;
    assign rsp.status          = q_reg[0].status;
    assign rsp.total_size      = q_reg[0].total_size;
    assign rsp.readable_count  = q_reg[0].readable_count;
    assign rsp.last            = q_reg[0].last;
endmodule
`default_nettype wire

[rtl/flash_descriptor_region_parser.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// flash_descriptor_region_parser: flash descriptor region walker
// Requests the signature, map, access and region words of a flash
// descriptor one at a time and reports each region and the totals.
// ----------------------------------------------------------------------------
//
//  Channel   Role    Handshake           Word
//  cmd       sink    valid/ready         command, read_data, read_error
//  rsp       source  valid/ready         request, region record or finish
//  apb       slave   psel/penable        region_present_mask at address 0
//
//  A command word is taken into an input register, decoded from that register
//  and its results written to a three-entry result queue.
//  While rsp.ready holds, every one-result word can be taken each cycle;
//  a region word gives two, so the result port, one word a cycle, paces it.
//  cmd.ready drops only while the queue cannot take two more words.
//  rst_n clears the sequencer, queue and input register at once and sets the
//  present mask to region zero only; no clearing pass follows.
//
module flash_descriptor_region_parser #(
    parameter int NUM_REGION_IDS = fdrp_pkg::NUM_REGION_IDS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    fdrp_cmd_if.sink                        cmd,
    fdrp_rsp_if.source                      rsp,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [fdrp_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [fdrp_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [fdrp_pkg::CFG_DATA_W-1:0] prdata,
    output logic                            pready
);
    import fdrp_pkg::*;

    logic                       in_vld_reg;
    cmd_word_t                  in_word_reg;
    logic                       q_room;
    logic                       consume;
    parse_state_t               state_reg;
    parse_state_t               state_next;
    logic [1:0]                 res_count;
    result_t                    res0;
    result_t                    res1;
    logic [MASK_W-1:0]          mask_reg;
    logic [CFG_INDEX_W-1:0]     cfg_index;
    logic                       cfg_write;

    // Configuration register port.
    assign pready    = 1'b1;
    assign cfg_index = paddr[CFG_ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= MASK_RESET;
        end
        else if (cfg_write && (cfg_index == REG_REGION_PRESENT_MASK))
        begin
            mask_reg <= pwdata[MASK_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (cfg_index)
            REG_REGION_PRESENT_MASK: prdata = {{(CFG_DATA_W-MASK_W){1'b0}}, mask_reg};
            default:                 prdata = '0;
        endcase
    end

    // Input register: refilled whenever its word is consumed or it is empty.
    assign consume   = in_vld_reg && q_room;
    assign cmd.ready = !in_vld_reg || consume;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (cmd.ready)
        begin
            in_vld_reg <= cmd.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ready && cmd.valid)
        begin
            in_word_reg.command    <= cmd.command;
            in_word_reg.read_data  <= cmd.read_data;
            in_word_reg.read_error <= cmd.read_error;
        end
    end

    // Sequencer decode.
    fdrp_step #(
        .NUM_REGION_IDS (NUM_REGION_IDS)
    ) u_step (
        .cmd_word     (in_word_reg),
        .state_cur    (state_reg),
        .present_mask (mask_reg),
        .state_next   (state_next),
        .res_count    (res_count),
        .res0         (res0),
        .res1         (res1)
    );

    // Parse state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase          <= PH_IDLE;
            state_reg.access_word    <= '0;
            state_reg.current_region <= '0;
            state_reg.max_limit      <= '0;
            state_reg.readable_total <= '0;
        end
        else if (consume)
        begin
            state_reg <= state_next;
        end
    end

    // Result queue.
    fdrp_result_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_count (consume ? res_count : 2'd0),
        .push0      (res0),
        .push1      (res1),
        .room       (q_room),
        .rsp        (rsp)
    );
endmodule
`default_nettype wire

[rtl/fdrp_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fdrp_checker: port-level checks for the region parser
// Watches the result channel for handshake stability and for the rules that
// tie the kind of a word to its other fields.
// ----------------------------------------------------------------------------
module fdrp_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           rsp_valid,
    input logic                           rsp_ready,
    input logic [fdrp_pkg::KIND_W-1:0]    rsp_kind,
    input logic [fdrp_pkg::STATUS_W-1:0]  rsp_status,
    input logic [fdrp_pkg::SIZE_W-1:0]    rsp_total_size,
    input logic [fdrp_pkg::COUNT_W-1:0]   rsp_readable_count,
    input logic                           rsp_last
);
    import fdrp_pkg::*;

    // A stalled word stays offered with its kind and last flag unchanged.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_last))
        else $error("result word changed while stalled");

    // Requests and finishes close the results of a command word.
    a_req_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_kind == KIND_REQUEST || rsp_kind == KIND_FINISH) |-> rsp_last)
        else $error("request or finish word without last");

    // A region record is always followed by another word of the same command.
    a_rec_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_kind == KIND_RECORD |-> !rsp_last)
        else $error("region record marked last");

    // A failed parse carries no totals.
    a_fail_totals: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_kind == KIND_FINISH && rsp_status != ST_OK
        |-> rsp_total_size == '0 && rsp_readable_count == '0)
        else $error("failed parse reports totals");
endmodule

bind flash_descriptor_region_parser fdrp_checker u_fdrp_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .rsp_valid          (rsp.valid),
    .rsp_ready          (rsp.ready),
    .rsp_kind           (rsp.kind),
    .rsp_status         (rsp.status),
    .rsp_total_size     (rsp.total_size),
    .rsp_readable_count (rsp.readable_count),
    .rsp_last           (rsp.last)
);
`default_nettype wire
